### hdl/hdr_backlight_duty_from_luminance_top_macros.svh
// Assertion shorthands, clocked on clk and held off while rst_n is low
`ifndef HDR_BACKLIGHT_DUTY_FROM_LUMINANCE_TOP_MACROS_SVH
`define HDR_BACKLIGHT_DUTY_FROM_LUMINANCE_TOP_MACROS_SVH

// same-cycle implication
`define HBD_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hbd assertion failed");

// next-cycle implication
`define HBD_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hbd assertion failed");

`endif

### hdl/hbd_pkg.sv
package hbd_pkg;

    localparam int MAP_POINTS_DEF = 11;
    localparam int DEF_POINTS     = 11;
    localparam int LUM_W          = 16;
    localparam int DUTY_W         = 8;
    localparam int GAIN_W         = 16;
    localparam int GNUM_W         = LUM_W + 8;

    // configuration register indexes
    localparam logic [2:0] CFG_MIN_DUTY   = 3'd0;
    localparam logic [2:0] CFG_MAX_DUTY   = 3'd1;
    localparam logic [2:0] CFG_LUM_FLOOR  = 3'd2;
    localparam logic [2:0] CFG_LUM_CEIL   = 3'd3;
    localparam logic [2:0] CFG_TIER_LIMIT = 3'd4;
    localparam logic [2:0] CFG_PANEL_PEAK = 3'd5;
    localparam logic [2:0] CFG_USE_MAP    = 3'd6;

    // register reset values
    localparam logic [DUTY_W-1:0] RST_MIN_DUTY   = 8'd0;
    localparam logic [DUTY_W-1:0] RST_MAX_DUTY   = 8'd255;
    localparam logic [LUM_W-1:0]  RST_LUM_FLOOR  = 16'd89;
    localparam logic [LUM_W-1:0]  RST_LUM_CEIL   = 16'd654;
    localparam logic [LUM_W-1:0]  RST_TIER_LIMIT = 16'd1000;
    localparam logic [LUM_W-1:0]  RST_PANEL_PEAK = 16'd400;

    localparam logic [GAIN_W-1:0] GAIN_UNITY = 16'd256;
    localparam logic [GAIN_W-1:0] GAIN_SAT   = 16'hFFFF;

    // duty source picked for a result
    typedef enum logic [1:0] {
        SEL_MIN,
        SEL_MAX,
        SEL_INTERP
    } sel_t;

    // map search outcome
    typedef struct packed {
        logic             le0;
        logic             found;
        logic [LUM_W-1:0] lo_lum;
        logic [LUM_W-1:0] hi_lum;
    } srch_t;

    // carried alongside the segment duty division
    typedef struct packed {
        logic [LUM_W-1:0] light;
        srch_t            srch;
        logic             above;
        logic             below;
        logic             over;
        logic             span_neg;
    } mid_t;

    // carried alongside the interpolation division
    typedef struct packed {
        logic              neg;
        logic [DUTY_W-1:0] base;
        sel_t              sel;
        logic              above;
    } tail_t;

    // calibration map contents after reset
    function automatic logic [LUM_W-1:0] default_lum(input int i);
        logic [LUM_W-1:0] v;
        case (i)
            0:       v = 16'd89;
            1:       v = 16'd144;
            2:       v = 16'd206;
            3:       v = 16'd265;
            4:       v = 16'd326;
            5:       v = 16'd384;
            6:       v = 16'd438;
            7:       v = 16'd495;
            8:       v = 16'd549;
            9:       v = 16'd601;
            default: v = 16'd654;
        endcase
        return v;
    endfunction

endpackage

### hdl/hbd_div.sv
// Pipelined restoring divider: one quotient bit per stage, NUM_W stages
module hbd_div #(
    parameter int NUM_W  = 24,
    parameter int DEN_W  = 16,
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_vld,
    input  logic [NUM_W-1:0]  in_num,
    input  logic [DEN_W-1:0]  in_den,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_vld,
    output logic [NUM_W-1:0]  out_quo,
    output logic [SIDE_W-1:0] out_side
);

    logic              vld_reg  [1:NUM_W];
    logic [NUM_W-1:0]  num_reg  [1:NUM_W];
    logic [DEN_W-1:0]  rem_reg  [1:NUM_W];
    logic [DEN_W-1:0]  den_reg  [1:NUM_W];
    logic [SIDE_W-1:0] side_reg [1:NUM_W];

    logic [NUM_W-1:0]  num_next [1:NUM_W];
    logic [DEN_W-1:0]  rem_next [1:NUM_W];

    // one shift-compare-subtract step per stage
    always_comb
    begin
        logic [NUM_W-1:0] s_num;
        logic [DEN_W-1:0] s_rem;
        logic [DEN_W-1:0] s_den;
        logic [DEN_W:0]   trial;
        logic             qbit;
        for (int s = 0; s < NUM_W; s++)
        begin
            if (s == 0)
            begin
                s_num = in_num;
                s_rem = '0;
                s_den = in_den;
            end
            else
            begin
                s_num = num_reg[s];
                s_rem = rem_reg[s];
                s_den = den_reg[s];
            end
            trial = {s_rem, s_num[NUM_W-1]};
            qbit  = (trial >= {1'b0, s_den});
            if (qbit)
                rem_next[s+1] = DEN_W'(trial - {1'b0, s_den});
            else
                rem_next[s+1] = trial[DEN_W-1:0];
            num_next[s+1] = {s_num[NUM_W-2:0], qbit};
        end
    end

    // stage registers; valid bits reset, payload does not
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 1; s <= NUM_W; s++)
                vld_reg[s] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[1] <= in_vld;
            for (int s = 2; s <= NUM_W; s++)
                vld_reg[s] <= vld_reg[s-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den_reg[1]  <= in_den;
            side_reg[1] <= in_side;
            for (int s = 2; s <= NUM_W; s++)
            begin
                den_reg[s]  <= den_reg[s-1];
                side_reg[s] <= side_reg[s-1];
            end
            for (int s = 1; s <= NUM_W; s++)
            begin
                num_reg[s] <= num_next[s];
                rem_reg[s] <= rem_next[s];
            end
        end
    end

    assign out_vld  = vld_reg[NUM_W];
    assign out_quo  = num_reg[NUM_W];
    assign out_side = side_reg[NUM_W];

endmodule

### hdl/hbd_map.sv
// Calibration map store and segment search
module hbd_map
    import hbd_pkg::*;
#(
    parameter int MAP_POINTS = MAP_POINTS_DEF,
    parameter int KW         = $clog2(MAP_POINTS)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [3:0]       wr_idx,
    input  logic [LUM_W-1:0] wr_lum,
    input  logic [LUM_W-1:0] light,
    output srch_t            srch,
    output logic [KW-1:0]    seg
);

    logic [LUM_W-1:0] map_reg [0:MAP_POINTS-1];

    // per-entry write; an index past the map matches no entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAP_POINTS; i++)
                map_reg[i] <= default_lum(i);
        end
        else if (wr_en)
        begin
            for (int i = 0; i < MAP_POINTS; i++)
                if (32'(wr_idx) == i)
                    map_reg[i] <= wr_lum;
        end
    end

    // first entry from 1 upwards at or above the light
    always_comb
    begin
        logic taken;
        taken       = 1'b0;
        srch.le0    = (light <= map_reg[0]);
        srch.lo_lum = '0;
        srch.hi_lum = '0;
        seg         = '0;
        for (int k = 1; k < MAP_POINTS; k++)
        begin
            if (!taken && map_reg[k] >= light)
            begin
                taken       = 1'b1;
                srch.lo_lum = map_reg[k-1];
                srch.hi_lum = map_reg[k];
                seg         = KW'(k);
            end
        end
        srch.found = taken;
    end

endmodule

### hdl/hdr_backlight_duty_from_luminance_top.sv
// Pipeline from input request to result: input and search stages, two stages for the
// segment end duties, select and multiply stages, the 24-bit interpolation and gain
// dividers, and the output register.
// Throughput: one request per cycle; map writes give no result; a held result stalls all.
// Reset: asynchronous, active low; registers and calibration map return to defaults.
`include "hdr_backlight_duty_from_luminance_top_macros.svh"

module hdr_backlight_duty_from_luminance_top
    import hbd_pkg::*;
#(
    parameter int MAP_POINTS = MAP_POINTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [15:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,  // entry_index, entry_lum, content_light, mastering_peak
    input  logic        s_tuser,  // cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,  // backlight_duty, eotf_gain
    output logic        m_tuser   // above_tier
);

    localparam int KW    = $clog2(MAP_POINTS);
    localparam int SEG_W = KW + DUTY_W;
    localparam int TAIL_W = $bits(tail_t);

    // reciprocal of (points - 1), exact for every numerator below 2^SEG_W
    localparam int     DIV_D  = MAP_POINTS - 1;
    localparam int     RCP_SH = SEG_W + KW;
    localparam int     RCP_W  = SEG_W + 2;
    localparam longint RCP_M  = ((longint'(1) << RCP_SH) + longint'(DIV_D) - 1)
                                / longint'(DIV_D);
    localparam int     PRD_W  = SEG_W + RCP_W;

    // configuration registers
    logic [DUTY_W-1:0] min_duty_reg, max_duty_reg;
    logic [LUM_W-1:0]  lum_floor_reg, lum_ceil_reg, tier_limit_reg, panel_peak_reg;
    logic              use_map_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_duty_reg   <= RST_MIN_DUTY;
            max_duty_reg   <= RST_MAX_DUTY;
            lum_floor_reg  <= RST_LUM_FLOOR;
            lum_ceil_reg   <= RST_LUM_CEIL;
            tier_limit_reg <= RST_TIER_LIMIT;
            panel_peak_reg <= RST_PANEL_PEAK;
            use_map_reg    <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_MIN_DUTY:   min_duty_reg   <= cfg_wdata[DUTY_W-1:0];
                CFG_MAX_DUTY:   max_duty_reg   <= cfg_wdata[DUTY_W-1:0];
                CFG_LUM_FLOOR:  lum_floor_reg  <= cfg_wdata;
                CFG_LUM_CEIL:   lum_ceil_reg   <= cfg_wdata;
                CFG_TIER_LIMIT: tier_limit_reg <= cfg_wdata;
                CFG_PANEL_PEAK: panel_peak_reg <= cfg_wdata;
                CFG_USE_MAP:    use_map_reg    <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // whole pipe advances unless a result is held
    logic en;
    logic out_vld_reg;
    assign en       = !out_vld_reg || m_tready;
    assign s_tready = en;

    // stage 0: input request, light substitution
    logic             v0_reg, cmd0_reg;
    logic [3:0]       idx0_reg;
    logic [LUM_W-1:0] elum0_reg, light0_reg;
    logic [LUM_W-1:0] light_next;

    assign light_next = (s_tdata[35:20] < s_tdata[51:36]) ? panel_peak_reg : s_tdata[35:20];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else if (en)
            v0_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cmd0_reg   <= s_tuser;
            idx0_reg   <= s_tdata[3:0];
            elum0_reg  <= s_tdata[19:4];
            light0_reg <= light_next;
        end
    end

    // stage 1: map write or search
    srch_t         srch;
    logic [KW-1:0] seg;

    hbd_map #(
        .MAP_POINTS(MAP_POINTS),
        .KW        (KW)
    ) u_map (
        .clk   (clk),
        .rst_n (rst_n),
        .wr_en (en && v0_reg && !cmd0_reg),
        .wr_idx(idx0_reg),
        .wr_lum(elum0_reg),
        .light (light0_reg),
        .srch  (srch),
        .seg   (seg)
    );

    logic          v1_reg;
    mid_t          mid1_reg;
    logic [KW-1:0] seg1_reg;
    mid_t          mid1_next;

    always_comb
    begin
        mid1_next.light    = light0_reg;
        mid1_next.srch     = srch;
        mid1_next.above    = (light0_reg > tier_limit_reg);
        mid1_next.below    = (light0_reg < lum_floor_reg);
        mid1_next.over     = (light0_reg > lum_ceil_reg);
        mid1_next.span_neg = (max_duty_reg < min_duty_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (en)
            v1_reg <= v0_reg && cmd0_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mid1_reg <= mid1_next;
            seg1_reg <= seg;
        end
    end

    // segment end duties: j * span, then divided by (points - 1)
    logic [DUTY_W-1:0] span_mag;
    logic [SEG_W-1:0]  lo_num, hi_num;

    assign span_mag = (max_duty_reg < min_duty_reg) ? (min_duty_reg - max_duty_reg)
                                                    : (max_duty_reg - min_duty_reg);
    assign lo_num   = SEG_W'(seg1_reg - KW'(1)) * SEG_W'(span_mag);
    assign hi_num   = SEG_W'(seg1_reg) * SEG_W'(span_mag);

    // stage 2a: segment products
    logic             v2a_reg;
    logic [SEG_W-1:0] lo_num2a_reg, hi_num2a_reg;
    mid_t             mid2a_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2a_reg <= 1'b0;
        else if (en)
            v2a_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lo_num2a_reg <= lo_num;
            hi_num2a_reg <= hi_num;
            mid2a_reg    <= mid1_reg;
        end
    end

    // stage 2b: quotients by reciprocal multiply
    logic [PRD_W-1:0] lo_prd, hi_prd;
    logic             v2_reg;
    logic [SEG_W-1:0] lo_q_reg, hi_q_reg;
    mid_t             mid2_reg;

    assign lo_prd = PRD_W'(lo_num2a_reg) * PRD_W'(RCP_M);
    assign hi_prd = PRD_W'(hi_num2a_reg) * PRD_W'(RCP_M);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (en)
            v2_reg <= v2a_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lo_q_reg <= SEG_W'(lo_prd >> RCP_SH);
            hi_q_reg <= SEG_W'(hi_prd >> RCP_SH);
            mid2_reg <= mid2a_reg;
        end
    end

    // stage 3: pick the interpolation operands and the duty source
    logic signed [DUTY_W+1:0] lo_s, hi_s, delta;
    logic                     v3_reg;
    logic [LUM_W-1:0]         mnum3_reg, mden3_reg, light3_reg;
    logic [DUTY_W-1:0]        mag3_reg;
    tail_t                    tail3_reg;
    logic [LUM_W-1:0]         mnum_next, mden_next;
    logic [DUTY_W-1:0]        mag_next;
    tail_t                    tail_next;

    assign lo_s  = mid2_reg.span_neg
                   ? $signed({2'b00, min_duty_reg}) - $signed({2'b00, lo_q_reg[7:0]})
                   : $signed({2'b00, min_duty_reg}) + $signed({2'b00, lo_q_reg[7:0]});
    assign hi_s  = mid2_reg.span_neg
                   ? $signed({2'b00, min_duty_reg}) - $signed({2'b00, hi_q_reg[7:0]})
                   : $signed({2'b00, min_duty_reg}) + $signed({2'b00, hi_q_reg[7:0]});
    assign delta = hi_s - lo_s;

    always_comb
    begin
        tail_next.above = mid2_reg.above;
        if (use_map_reg)
        begin
            mnum_next      = mid2_reg.light - mid2_reg.srch.lo_lum;
            mden_next      = mid2_reg.srch.hi_lum - mid2_reg.srch.lo_lum;
            tail_next.neg  = delta[DUTY_W+1];
            mag_next       = delta[DUTY_W+1] ? DUTY_W'(-delta) : delta[DUTY_W-1:0];
            tail_next.base = lo_s[DUTY_W-1:0];
        end
        else
        begin
            mnum_next      = mid2_reg.light - lum_floor_reg;
            mden_next      = lum_ceil_reg - lum_floor_reg;
            tail_next.neg  = mid2_reg.span_neg;
            mag_next       = span_mag;
            tail_next.base = min_duty_reg;
        end
        // bypass first, then floor before ceiling
        if (mid2_reg.above)
            tail_next.sel = SEL_MAX;
        else if (mid2_reg.below)
            tail_next.sel = SEL_MIN;
        else if (mid2_reg.over)
            tail_next.sel = SEL_MAX;
        else if (use_map_reg)
        begin
            if (mid2_reg.srch.le0)
                tail_next.sel = SEL_MIN;
            else if (!mid2_reg.srch.found)
                tail_next.sel = SEL_MAX;
            else
                tail_next.sel = SEL_INTERP;
        end
        else if (lum_ceil_reg == lum_floor_reg)
            tail_next.sel = SEL_MIN;
        else
            tail_next.sel = SEL_INTERP;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else if (en)
            v3_reg <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mnum3_reg  <= mnum_next;
            mden3_reg  <= mden_next;
            mag3_reg   <= mag_next;
            tail3_reg  <= tail_next;
            light3_reg <= mid2_reg.light;
        end
    end

    // stage 4: product of offset and duty step
    logic              v4_reg;
    logic [GNUM_W-1:0] prod4_reg;
    logic [LUM_W-1:0]  mden4_reg, light4_reg;
    tail_t             tail4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v4_reg <= 1'b0;
        else if (en)
            v4_reg <= v3_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod4_reg  <= GNUM_W'(mnum3_reg) * GNUM_W'(mag3_reg);
            mden4_reg  <= mden3_reg;
            tail4_reg  <= tail3_reg;
            light4_reg <= light3_reg;
        end
    end

    // interpolation and gain divisions side by side
    logic              c_vld, d_vld, lz5;
    logic [GNUM_W-1:0] c_q, d_q;
    logic [TAIL_W-1:0] tail5_bits;
    tail_t             tail5;

    hbd_div #(.NUM_W(GNUM_W), .DEN_W(LUM_W), .SIDE_W(TAIL_W)) u_div_interp (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_vld(v4_reg), .in_num(prod4_reg), .in_den(mden4_reg),
        .in_side(tail4_reg),
        .out_vld(c_vld), .out_quo(c_q), .out_side(tail5_bits)
    );

    hbd_div #(.NUM_W(GNUM_W), .DEN_W(LUM_W), .SIDE_W(1)) u_div_gain (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_vld(v4_reg), .in_num({panel_peak_reg, 8'd0}), .in_den(light4_reg),
        .in_side(light4_reg == '0),
        .out_vld(d_vld), .out_quo(d_q), .out_side(lz5)
    );

    assign tail5 = tail_t'(tail5_bits);

    // output register
    logic [DUTY_W-1:0] duty_next, duty_reg;
    logic [GAIN_W-1:0] gain_next, gain_reg;
    logic              above_reg;

    always_comb
    begin
        case (tail5.sel)
            SEL_MIN:    duty_next = min_duty_reg;
            SEL_MAX:    duty_next = max_duty_reg;
            SEL_INTERP: duty_next = tail5.neg ? tail5.base - c_q[DUTY_W-1:0]
                                              : tail5.base + c_q[DUTY_W-1:0];
            default:    duty_next = max_duty_reg;
        endcase
        if (tail5.above)
            gain_next = GAIN_UNITY;
        else if (lz5 || d_q[GNUM_W-1:GAIN_W] != '0)
            gain_next = GAIN_SAT;
        else
            gain_next = d_q[GAIN_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (en)
            out_vld_reg <= c_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            duty_reg  <= duty_next;
            gain_reg  <= gain_next;
            above_reg <= tail5.above;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {gain_reg, duty_reg};
    assign m_tuser  = above_reg;

    // checks
    `HBD_ASSERT_IMP(a_div_aligned, 1'b1, c_vld == d_vld)
    `HBD_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)
    `HBD_ASSERT_IMP(a_interp_den, v3_reg && use_map_reg && tail3_reg.sel == SEL_INTERP,
                    mden3_reg != '0)
    `HBD_ASSERT_IMP(a_bypass_out, m_tvalid && m_tuser,
                    m_tdata[23:8] == GAIN_UNITY && m_tdata[7:0] == max_duty_reg)
    `HBD_ASSERT_NXT(a_take, s_tvalid && s_tready, v0_reg)

endmodule

### tb/hbd_checker.sv
// Watches the config port and both streams, predicts the duty/gain result of
// every evaluate request and compares it with what the block returns.
module hbd_checker
    import hbd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [15:0] cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [55:0] s_tdata,  // entry_index, entry_lum, content_light, mastering_peak
    input  logic        s_tuser,  // cmd
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,  // backlight_duty, eotf_gain
    input  logic        m_tuser,  // above_tier
    output int          errors,
    output int          outstanding,
    output int          evals_seen
);

    typedef struct packed {
        logic [DUTY_W-1:0] duty;
        logic [GAIN_W-1:0] gain;
        logic              above;
    } duty_gain_t;

    duty_gain_t        duty_gain_q[$];

    // shadow of the block's registers and calibration map
    logic [LUM_W-1:0]  cal_map [MAP_POINTS_DEF];
    logic [DUTY_W-1:0] min_duty, max_duty;
    logic [LUM_W-1:0]  lum_floor, lum_ceil, tier_limit, panel_peak;
    logic              use_map;

    assign outstanding = duty_gain_q.size();

    // duty interpolated over the calibration map
    function automatic logic [DUTY_W-1:0] map_duty(input logic [LUM_W-1:0] lum);
        longint span, lo, hi, num, den;
        span = longint'(max_duty) - longint'(min_duty);
        if (lum <= cal_map[0])
            return min_duty;
        for (int k = 1; k < MAP_POINTS_DEF; k++)
        begin
            if (cal_map[k] >= lum)
            begin
                lo  = longint'(min_duty) + (longint'(k - 1) * span) / (MAP_POINTS_DEF - 1);
                hi  = longint'(min_duty) + (longint'(k) * span) / (MAP_POINTS_DEF - 1);
                num = longint'(lum) - longint'(cal_map[k-1]);
                den = longint'(cal_map[k]) - longint'(cal_map[k-1]);
                if (den <= 0)
                    return hi[7:0];
                lo = lo + (num * (hi - lo)) / den;
                return lo[7:0];
            end
        end
        return max_duty;
    endfunction

    // duty on the straight line from floor to ceiling
    function automatic logic [DUTY_W-1:0] line_duty(input logic [LUM_W-1:0] lum);
        longint span, num, den, d;
        span = longint'(max_duty) - longint'(min_duty);
        den  = longint'(lum_ceil) - longint'(lum_floor);
        num  = longint'(lum) - longint'(lum_floor);
        if (den <= 0)
            return min_duty;
        d = longint'(min_duty) + (num * span) / den;
        return d[7:0];
    endfunction

    function automatic duty_gain_t duty_gain_for(input logic [LUM_W-1:0] light,
                                                 input logic [LUM_W-1:0] mpeak);
        duty_gain_t r;
        longint     g;
        if (light < mpeak)
            light = panel_peak;
        if (light > tier_limit)
        begin
            r.duty  = max_duty;
            r.gain  = GAIN_UNITY;
            r.above = 1'b1;
        end
        else
        begin
            r.above = 1'b0;
            if (light == 0)
                r.gain = GAIN_SAT;
            else
            begin
                g = (longint'(panel_peak) * 256) / longint'(light);
                r.gain = (g > 65535) ? GAIN_SAT : g[15:0];
            end
            if (light < lum_floor)
                r.duty = min_duty;
            else if (light > lum_ceil)
                r.duty = max_duty;
            else if (use_map)
                r.duty = map_duty(light);
            else
                r.duty = line_duty(light);
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        duty_gain_t exp_r;
        if (!rst_n)
        begin
            for (int i = 0; i < MAP_POINTS_DEF; i++)
                cal_map[i] = default_lum(i);
            min_duty   = RST_MIN_DUTY;
            max_duty   = RST_MAX_DUTY;
            lum_floor  = RST_LUM_FLOOR;
            lum_ceil   = RST_LUM_CEIL;
            tier_limit = RST_TIER_LIMIT;
            panel_peak = RST_PANEL_PEAK;
            use_map    = 1'b1;
            duty_gain_q.delete();
            errors     = 0;
            evals_seen = 0;
        end
        else
        begin
            // register writes
            if (cfg_we)
            begin
                case (cfg_addr)
                    CFG_MIN_DUTY:   min_duty   = cfg_wdata[7:0];
                    CFG_MAX_DUTY:   max_duty   = cfg_wdata[7:0];
                    CFG_LUM_FLOOR:  lum_floor  = cfg_wdata;
                    CFG_LUM_CEIL:   lum_ceil   = cfg_wdata;
                    CFG_TIER_LIMIT: tier_limit = cfg_wdata;
                    CFG_PANEL_PEAK: panel_peak = cfg_wdata;
                    CFG_USE_MAP:    use_map    = cfg_wdata[0];
                    default: ;
                endcase
            end
            // accepted request: map write or evaluate
            if (s_tvalid && s_tready)
            begin
                if (!s_tuser)
                begin
                    if (s_tdata[3:0] < MAP_POINTS_DEF)
                        cal_map[s_tdata[3:0]] = s_tdata[19:4];
                end
                else
                    duty_gain_q.push_back(duty_gain_for(s_tdata[35:20], s_tdata[51:36]));
            end
            // returned result
            if (m_tvalid && m_tready)
            begin
                evals_seen++;
                if (duty_gain_q.size() == 0)
                begin
                    $error("result with nothing expected: duty %0d gain %0d above %0d",
                           m_tdata[7:0], m_tdata[23:8], m_tuser);
                    errors++;
                end
                else
                begin
                    exp_r = duty_gain_q.pop_front();
                    if (m_tdata[7:0] !== exp_r.duty)
                    begin
                        $error("backlight_duty expected %0d actual %0d", exp_r.duty, m_tdata[7:0]);
                        errors++;
                    end
                    if (m_tdata[23:8] !== exp_r.gain)
                    begin
                        $error("eotf_gain expected %0d actual %0d", exp_r.gain, m_tdata[23:8]);
                        errors++;
                    end
                    if (m_tuser !== exp_r.above)
                    begin
                        $error("above_tier expected %0d actual %0d", exp_r.above, m_tuser);
                        errors++;
                    end
                end
            end
        end
    end

endmodule

### tb/tb_hdr_backlight_duty_from_luminance_top.sv
module tb_hdr_backlight_duty_from_luminance_top;
    import hbd_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_addr;
    logic [15:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;   // entry_index, entry_lum, content_light, mastering_peak
    logic        s_tuser;   // cmd
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // backlight_duty, eotf_gain
    logic        m_tuser;   // above_tier

    int errors, outstanding, evals_seen;
    int send_idle, recv_idle;
    int hold_cycles;
    int requests_sent;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_EVAL  = 1'b1;
    localparam int   SETTLE    = 60;

    hdr_backlight_duty_from_luminance_top DUT (.*);

    hbd_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

    // receiver: random stalls, plus a long hold-off when asked
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                m_tready = 1'b0;
                hold_cycles--;
            end
            else
                m_tready = ($urandom_range(99) >= recv_idle);
        end
    end

    task automatic write_reg(input logic [2:0] addr, input logic [15:0] val);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_addr  = addr;
        cfg_wdata = val;
        @(posedge clk);
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    task automatic send_request(input logic cmd, input logic [3:0] idx,
                                input logic [15:0] elum, input logic [15:0] light,
                                input logic [15:0] mpeak);
        @(negedge clk);
        while ($urandom_range(99) < send_idle)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = cmd;
        s_tdata  = {4'd0, mpeak, light, elum, idx};
        do
            @(posedge clk);
        while (!s_tready);
        requests_sent++;
    endtask

    // wait for every result, then let trailing map writes clear the pipeline
    task automatic drain();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic eval(input logic [15:0] light, input logic [15:0] mpeak);
        send_request(CMD_EVAL, 4'd0, 16'd0, light, mpeak);
    endtask

    task automatic load_map(input logic [3:0] idx, input logic [15:0] lum);
        send_request(CMD_WRITE, idx, lum, 16'd0, 16'd0);
    endtask

    task automatic write_all(input logic [7:0] mn, input logic [7:0] mx,
                             input logic [15:0] fl, input logic [15:0] ce,
                             input logic [15:0] tl, input logic [15:0] pk,
                             input logic um);
        write_reg(CFG_MIN_DUTY, {8'd0, mn});
        write_reg(CFG_MAX_DUTY, {8'd0, mx});
        write_reg(CFG_LUM_FLOOR, fl);
        write_reg(CFG_LUM_CEIL, ce);
        write_reg(CFG_TIER_LIMIT, tl);
        write_reg(CFG_PANEL_PEAK, pk);
        write_reg(CFG_USE_MAP, {15'd0, um});
    endtask

    // random traffic: mostly evaluates around the map range, some map loads
    task automatic random_requests(input int n);
        logic [15:0] light;
        int          r;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(99);
            if (r < 15)
            begin
                if ($urandom_range(9) == 0)
                    load_map(4'($urandom_range(15)), 16'($urandom));
                else
                    load_map(4'($urandom_range(10)), 16'($urandom_range(700)));
            end
            else
            begin
                case ($urandom_range(3))
                    0:       light = 16'($urandom);
                    1:       light = 16'($urandom_range(15));
                    default: light = 16'($urandom_range(1100));
                endcase
                if ($urandom_range(3) == 0)
                    eval(light, 16'($urandom));
                else
                    eval(light, 16'($urandom_range(light)));
            end
        end
    endtask

    task automatic set_pace(input int sp, input int rp);
        send_idle = sp;
        recv_idle = rp;
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = CFG_MIN_DUTY;
        cfg_wdata = 16'd0;
        s_tvalid = 1'b0;
        s_tdata = 56'd0;
        s_tuser = CMD_WRITE;
        hold_cycles = 0;
        requests_sent = 0;
        set_pace(0, 0);
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: reset settings and default map
        eval(16'd0, 16'd0);          // zero light
        eval(16'd0, 16'd1);          // light replaced by panel peak
        eval(16'd65535, 16'd0);      // above tier
        eval(16'd1000, 16'd65535);   // exactly at tier, then panel peak
        eval(16'd1000, 16'd0);       // above ceiling
        eval(16'd88, 16'd0);         // below floor
        eval(16'd89, 16'd0);         // at first map point
        eval(16'd90, 16'd0);
        eval(16'd300, 16'd300);
        eval(16'd654, 16'd0);
        eval(16'd655, 16'd0);
        load_map(4'd15, 16'hFFFF);   // out of range, ignored
        load_map(4'd5, 16'd100);     // non-monotonic map
        eval(16'd380, 16'd0);
        load_map(4'd10, 16'd500);    // last point lowered; search still finds entry 9
        eval(16'd600, 16'd0);
        load_map(4'd0, 16'hFFFF);
        eval(16'd400, 16'd0);
        load_map(4'd0, 16'd89);
        load_map(4'd5, 16'd384);
        load_map(4'd10, 16'd654);
        eval(16'd420, 16'd0);
        drain();

        // extremes: inverted duty span, full-range line, saturating gain
        write_all(8'd255, 8'd0, 16'd0, 16'd65535, 16'd65535, 16'd65535, 1'b0);
        eval(16'd1, 16'd0);
        eval(16'd0, 16'd0);
        eval(16'd65535, 16'd0);
        eval(16'd32768, 16'd0);
        set_pace(25, 76);
        random_requests(50);
        drain();

        // floor equals ceiling, zero tier and panel peak
        write_all(8'd0, 8'd255, 16'd500, 16'd500, 16'd0, 16'd0, 1'b0);
        eval(16'd500, 16'd0);
        eval(16'd0, 16'd0);
        set_pace(76, 25);
        random_requests(40);
        drain();

        // map path with inverted span
        write_all(8'd200, 8'd10, 16'd0, 16'd65535, 16'd65535, 16'd400, 1'b1);
        set_pace(25, 76);
        random_requests(50);
        drain();

        // long receiver hold-off while the sender keeps going
        write_all(8'd0, 8'd255, 16'd89, 16'd654, 16'd1000, 16'd400, 1'b1);
        set_pace(0, 0);
        hold_cycles = 400;
        random_requests(80);
        drain();

        // random settings across all idling modes
        for (int s = 0; s < 6; s++)
        begin
            write_all(8'($urandom), 8'($urandom), 16'($urandom_range(300)),
                      16'($urandom_range(1000)), 16'($urandom_range(1200)),
                      16'($urandom), 1'($urandom));
            case (s % 3)
                0:       set_pace(25, 76);
                1:       set_pace(76, 25);
                default: set_pace(0, 0);
            endcase
            random_requests(35);
            drain();
        end

        $display("Sent %0d requests (map loads and evaluates) over 11 settings,", requests_sent);
        $display("%0d results checked", evals_seen);
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
